FILE: design/sirs_pkg.sv
// shared types, constants and the symbol table check for the radix symbol writer
package sirs_pkg;

    localparam int unsigned MAX_SYMBOLS = 16;

    localparam logic [7:0] SYM_MINUS = 8'h2D;
    localparam logic [7:0] SYM_PLUS  = 8'h2B;
    localparam logic [7:0] SYM_SPACE = 8'h20;
    localparam logic [7:0] CTRL_LOW  = 8'h09;
    localparam logic [7:0] CTRL_HIGH = 8'h0D;

    localparam logic [1:0] REG_SYMBOL_COUNT = 2'd0;
    localparam logic [1:0] REG_SYMBOLS_LOW  = 2'd1;
    localparam logic [1:0] REG_SYMBOLS_HIGH = 2'd2;

    typedef struct packed {
        logic [4:0]       count;
        logic [15:0][7:0] symbols;
    } t_cfg;

    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
    } t_job;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIV,
        B_SIGN,
        B_EMIT
    } t_bstate;

    function automatic logic table_ok(input t_cfg cfg);
        logic       ok;
        logic [7:0] b;
        int         i;
        int         j;
        ok = 1'b1;
        if (cfg.count < 5'd2 || cfg.count > 5'(MAX_SYMBOLS)) begin
            ok = 1'b0;
        end
        for (i = 0; i < 16; i++) begin
            b = cfg.symbols[i];
            if (5'(i) < cfg.count) begin
                if (b == 8'h00 || b == SYM_PLUS || b == SYM_MINUS || b == SYM_SPACE) begin
                    ok = 1'b0;
                end
                if (b >= CTRL_LOW && b <= CTRL_HIGH) begin
                    ok = 1'b0;
                end
                for (j = i + 1; j < 16; j++) begin
                    if (5'(j) < cfg.count && cfg.symbols[j] == b) begin
                        ok = 1'b0;
                    end
                end
            end
        end
        return ok;
    endfunction

endpackage

FILE: design/signed_integer_to_radix_symbols.sv
// top level: signed integer to radix symbols with register port
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+------------------------------
//  input    | i_in_valid / o_in_stall   | i_number (signed 32)
//  output   | o_out_valid / i_out_stall | o_symbol (8), o_last_symbol
//  config   | psel penable pwrite pready| paddr (5), pwdata/prdata (64)
//
//  each digit is found by dividing the running magnitude one significant byte at a time
//  (1 to 4 bytes) in the eight-bit-per-cycle remainder divider; then the symbols,
//  sign included, leave through the output register
//  synchronous active-low reset clears control and the three registers to zero
//  output stall holds the output register; a two-entry queue lets the front keep
//  taking numbers until it fills, then o_in_stall rises
module signed_integer_to_radix_symbols (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_number,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_symbol,
    output logic               o_last_symbol,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready
);

    logic [4:0]     r_count;
    logic [63:0]    r_sym_low;
    logic [63:0]    r_sym_high;
    sirs_pkg::t_cfg w_cfg;
    logic           w_wr;
    logic           w_push;
    logic           w_q_full;
    logic           w_pop;
    logic           w_job_valid;
    sirs_pkg::t_job w_front_job;
    sirs_pkg::t_job w_back_job;

    assign pready        = 1'b1;
    assign w_wr          = psel && penable && pwrite && pready;
    assign w_cfg.count   = r_count;
    assign w_cfg.symbols = {r_sym_high, r_sym_low};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= 5'd0;
            r_sym_low  <= 64'd0;
            r_sym_high <= 64'd0;
        end else if (w_wr) begin
            case (paddr[4:3])
                sirs_pkg::REG_SYMBOL_COUNT: r_count    <= pwdata[4:0];
                sirs_pkg::REG_SYMBOLS_LOW:  r_sym_low  <= pwdata;
                sirs_pkg::REG_SYMBOLS_HIGH: r_sym_high <= pwdata;
                default: begin
                    r_count <= r_count;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[4:3])
            sirs_pkg::REG_SYMBOL_COUNT: prdata = {59'd0, r_count};
            sirs_pkg::REG_SYMBOLS_LOW:  prdata = r_sym_low;
            sirs_pkg::REG_SYMBOLS_HIGH: prdata = r_sym_high;
            default:                    prdata = 64'd0;
        endcase
    end

    sirs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_number   (i_number),
        .i_q_full   (w_q_full),
        .o_push     (w_push),
        .o_job      (w_front_job)
    );

    sirs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_front_job),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_job_valid),
        .o_job   (w_back_job)
    );

    sirs_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_job_valid   (w_job_valid),
        .i_job         (w_back_job),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_symbol      (o_symbol),
        .o_last_symbol (o_last_symbol)
    );

endmodule

FILE: design/sirs_front.sv
// front end: takes numbers, drops them on a rejected table, forms sign and magnitude
module sirs_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sirs_pkg::t_cfg     i_cfg,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_number,
    input  logic               i_q_full,
    output logic               o_push,
    output sirs_pkg::t_job     o_job
);

    logic        r_valid;
    logic [31:0] r_raw;
    logic        w_ok;
    logic        w_consume;

    assign w_ok      = sirs_pkg::table_ok(i_cfg);
    assign w_consume = r_valid && (!w_ok || !i_q_full);

    assign o_in_stall = r_valid && !w_consume;
    assign o_push     = w_consume && w_ok;
    assign o_job.neg  = r_raw[31];
    assign o_job.mag  = r_raw[31] ? 32'(32'd0 - r_raw) : r_raw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_valid <= 1'b1;
        end else if (w_consume) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_raw <= i_number;
        end
    end

endmodule

FILE: design/sirs_queue.sv
// two-entry job queue between front and back
module sirs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sirs_pkg::t_job i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output sirs_pkg::t_job o_job
);

    sirs_pkg::t_job r_mem [2];
    logic           r_wp;
    logic           r_rp;
    logic [1:0]     r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= !r_wp;
            end
            if (w_pop) begin
                r_rp <= !r_rp;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule

FILE: design/sirs_back.sv
// back end: byte-wise digit divider, digit stack and symbol output register
module sirs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sirs_pkg::t_cfg i_cfg,
    input  logic           i_job_valid,
    input  sirs_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output logic [7:0]     o_symbol,
    output logic           o_last_symbol
);

    sirs_pkg::t_bstate r_state;
    sirs_pkg::t_bstate n_state;

    logic [31:0] r_mag;
    logic [31:0] n_mag;
    logic [31:0] r_quo;
    logic [31:0] n_quo;
    logic [3:0]  r_rem;
    logic [3:0]  n_rem;
    logic [1:0]  r_k;
    logic [1:0]  n_k;
    logic        r_neg;
    logic        n_neg;
    logic [4:0]  r_wr;
    logic [4:0]  n_wr;
    logic        r_out_valid;
    logic        n_out_valid;
    logic [7:0]  r_sym;
    logic [7:0]  n_sym;
    logic        r_last;
    logic        n_last;
    logic [3:0]  r_digit [32];

    logic        w_can_load;
    logic        w_dig_we;
    logic [7:0]  w_byte;
    logic [7:0]  w_qb;
    logic [3:0]  w_rem;
    logic [31:0] w_quo;

    function automatic logic [1:0] top_byte(input logic [31:0] v);
        logic [1:0] k;
        if (v[31:24] != 8'd0) begin
            k = 2'd3;
        end else if (v[23:16] != 8'd0) begin
            k = 2'd2;
        end else if (v[15:8] != 8'd0) begin
            k = 2'd1;
        end else begin
            k = 2'd0;
        end
        return k;
    endfunction

    assign w_can_load    = !r_out_valid || !i_out_stall;
    assign o_out_valid   = r_out_valid;
    assign o_symbol      = r_sym;
    assign o_last_symbol = r_last;

    // eight restoring division steps on one byte of the magnitude
    always_comb begin
        logic [3:0] rem;
        logic [4:0] t;
        rem    = r_rem;
        w_byte = r_mag[{r_k, 3'b000} +: 8];
        w_qb   = 8'd0;
        for (int b = 7; b >= 0; b--) begin
            t = {rem, w_byte[b]};
            if (t >= i_cfg.count) begin
                w_qb[b] = 1'b1;
                rem     = 4'(t - i_cfg.count);
            end else begin
                rem = t[3:0];
            end
        end
        w_rem = rem;
        w_quo = r_quo;
        w_quo[{r_k, 3'b000} +: 8] = w_qb;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            sirs_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    n_state = sirs_pkg::B_DIV;
                end
            end
            sirs_pkg::B_DIV: begin
                if (r_k == 2'd0 && w_quo == 32'd0) begin
                    n_state = r_neg ? sirs_pkg::B_SIGN : sirs_pkg::B_EMIT;
                end
            end
            sirs_pkg::B_SIGN: begin
                if (w_can_load) begin
                    n_state = sirs_pkg::B_EMIT;
                end
            end
            sirs_pkg::B_EMIT: begin
                if (w_can_load && r_wr == 5'd0) begin
                    n_state = sirs_pkg::B_IDLE;
                end
            end
            default: begin
                n_state = sirs_pkg::B_IDLE;
            end
        endcase
    end

    always_comb begin
        n_mag       = r_mag;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_k         = r_k;
        n_neg       = r_neg;
        n_wr        = r_wr;
        n_out_valid = r_out_valid && i_out_stall;
        n_sym       = r_sym;
        n_last      = r_last;
        o_pop       = 1'b0;
        w_dig_we    = 1'b0;
        case (r_state)
            sirs_pkg::B_IDLE: begin
                if (i_job_valid) begin
                    o_pop = 1'b1;
                    n_mag = i_job.mag;
                    n_neg = i_job.neg;
                    n_quo = 32'd0;
                    n_rem = 4'd0;
                    n_k   = top_byte(i_job.mag);
                    n_wr  = 5'd0;
                end
            end
            sirs_pkg::B_DIV: begin
                n_rem = w_rem;
                n_quo = w_quo;
                if (r_k == 2'd0) begin
                    w_dig_we = 1'b1;
                    if (w_quo != 32'd0) begin
                        n_wr  = r_wr + 5'd1;
                        n_mag = w_quo;
                        n_quo = 32'd0;
                        n_rem = 4'd0;
                        n_k   = top_byte(w_quo);
                    end
                end else begin
                    n_k = r_k - 2'd1;
                end
            end
            sirs_pkg::B_SIGN: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_sym       = sirs_pkg::SYM_MINUS;
                    n_last      = 1'b0;
                end
            end
            sirs_pkg::B_EMIT: begin
                if (w_can_load) begin
                    n_out_valid = 1'b1;
                    n_sym       = i_cfg.symbols[r_digit[r_wr]];
                    n_last      = (r_wr == 5'd0);
                    if (r_wr != 5'd0) begin
                        n_wr = r_wr - 5'd1;
                    end
                end
            end
            default: begin
                n_out_valid = r_out_valid && i_out_stall;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sirs_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag  <= n_mag;
        r_quo  <= n_quo;
        r_rem  <= n_rem;
        r_k    <= n_k;
        r_neg  <= n_neg;
        r_wr   <= n_wr;
        r_sym  <= n_sym;
        r_last <= n_last;
        if (w_dig_we) begin
            r_digit[r_wr] <= w_rem;
        end
    end

    a_rem_below_radix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sirs_pkg::B_DIV |-> {1'b0, r_rem} < i_cfg.count)
        else $error("division remainder not below radix");

    a_minus_never_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_last |-> r_sym != sirs_pkg::SYM_MINUS)
        else $error("minus symbol marked last");

    a_sign_only_negative: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sirs_pkg::B_SIGN |-> r_neg)
        else $error("sign emitted for a non-negative number");

    a_idle_output_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sirs_pkg::B_IDLE && r_out_valid |-> r_last)
        else $error("back idle while item output unfinished");

endmodule

FILE: dv/signed_integer_to_radix_symbols_tb.sv
// self-checking testbench for the signed integer to radix symbols writer
`timescale 1ns / 1ps

module signed_integer_to_radix_symbols_tb;

    localparam int PAUSE_CYCLES   = 400;
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASES         = 12;
    localparam int PHASE_ITEMS    = 12;

    class radix_scoreboard;
        logic [4:0]  radix_reg;
        logic [63:0] syms_lo;
        logic [63:0] syms_hi;
        logic [7:0]  exp_symbols[$];
        bit          exp_last[$];
        int          errors;

        function new();
            radix_reg = '0;
            syms_lo   = '0;
            syms_hi   = '0;
            errors    = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [63:0] value);
            case (idx)
                sirs_pkg::REG_SYMBOL_COUNT: radix_reg = value[4:0];
                sirs_pkg::REG_SYMBOLS_LOW:  syms_lo   = value;
                sirs_pkg::REG_SYMBOLS_HIGH: syms_hi   = value;
                default: ;
            endcase
        endfunction

        function bit is_reserved(logic [7:0] b);
            return b == 8'h00 || b == sirs_pkg::SYM_PLUS || b == sirs_pkg::SYM_MINUS ||
                   b == sirs_pkg::SYM_SPACE ||
                   (b >= sirs_pkg::CTRL_LOW && b <= sirs_pkg::CTRL_HIGH);
        endfunction

        function logic [7:0] symbol_of(int d);
            if (d < 8) begin
                return syms_lo[8*d +: 8];
            end
            return syms_hi[8*(d-8) +: 8];
        endfunction

        function bit table_valid();
            int n;
            int i;
            int j;
            n = radix_reg;
            if (n < 2 || n > sirs_pkg::MAX_SYMBOLS) begin
                return 1'b0;
            end
            for (i = 0; i < n; i++) begin
                if (is_reserved(symbol_of(i))) begin
                    return 1'b0;
                end
                for (j = i + 1; j < n; j++) begin
                    if (symbol_of(j) == symbol_of(i)) begin
                        return 1'b0;
                    end
                end
            end
            return 1'b1;
        endfunction

        function void note_number(logic [31:0] raw);
            logic [31:0] mag;
            logic [31:0] radix;
            logic [7:0]  digs[$];
            if (!table_valid()) begin
                return;
            end
            radix = {27'd0, radix_reg};
            if (raw[31]) begin
                exp_symbols.push_back(sirs_pkg::SYM_MINUS);
                exp_last.push_back(1'b0);
                mag = 32'd0 - raw;
            end else begin
                mag = raw;
            end
            do begin
                digs.push_front(symbol_of(int'(mag % radix)));
                mag = mag / radix;
            end while (mag != 0);
            foreach (digs[i]) begin
                exp_symbols.push_back(digs[i]);
                exp_last.push_back(i == digs.size() - 1);
            end
        endfunction

        function void check_symbol(logic [7:0] symbol, logic last_symbol);
            logic [7:0] want_sym;
            bit         want_last;
            if (exp_symbols.size() == 0) begin
                $error("unexpected item: symbol %h last_symbol %b", symbol, last_symbol);
                errors++;
                return;
            end
            want_sym  = exp_symbols.pop_front();
            want_last = exp_last.pop_front();
            if (symbol !== want_sym) begin
                $error("symbol mismatch: expected %h, actual %h", want_sym, symbol);
                errors++;
            end
            if (last_symbol !== want_last) begin
                $error("last_symbol mismatch: expected %b, actual %b", want_last, last_symbol);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic signed [31:0] in_number;
    logic               out_valid;
    logic               out_stall;
    logic [7:0]         out_symbol;
    logic               out_last;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [4:0]         paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    radix_scoreboard sb = new();
    int  send_idle_pct;
    int  recv_idle_pct;
    bit  hold_request;
    int  idle_cycles;

    signed_integer_to_radix_symbols DUT (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_number      (in_number),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_symbol      (out_symbol),
        .o_last_symbol (out_last),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stall, or one long hold-off on request
    initial begin
        int hold_left;
        hold_left = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                out_stall <= 1'b1;
                hold_left--;
            end else begin
                out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            sb.check_symbol(out_symbol, out_last);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
            (psel && penable && pwrite && pready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_table(input logic [4:0] cnt, input logic [63:0] lo,
                              input logic [63:0] hi);
        write_reg(sirs_pkg::REG_SYMBOL_COUNT, {59'd0, cnt});
        write_reg(sirs_pkg::REG_SYMBOLS_LOW, lo);
        write_reg(sirs_pkg::REG_SYMBOLS_HIGH, hi);
    endtask

    task automatic send_number(input logic signed [31:0] n);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        in_number <= n;
        do @(posedge clk); while (in_stall);
        sb.note_number(n);
    endtask

    // drain all expected items, then give a busy block time to finish
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.exp_symbols.size() != 0) begin
            @(posedge clk);
        end
        repeat (PAUSE_CYCLES) @(posedge clk);
    endtask

    task automatic random_table(output logic [4:0] cnt, output logic [63:0] lo,
                                output logic [63:0] hi);
        logic [7:0] t[16];
        int         n;
        int         i;
        int         j;
        logic [7:0] b;
        bit         dup;
        n = $urandom_range(2, 16);
        for (i = 0; i < 16; i++) begin
            if (i < n) begin
                do begin
                    b   = 8'($urandom_range(255));
                    dup = 1'b0;
                    for (j = 0; j < i; j++) begin
                        if (t[j] == b) begin
                            dup = 1'b1;
                        end
                    end
                end while (dup || sb.is_reserved(b));
                t[i] = b;
            end else begin
                t[i] = 8'($urandom_range(255));
            end
        end
        case ($urandom_range(7))
            0: n = $urandom_range(31);
            1: begin
                case ($urandom_range(4))
                    0: b = 8'h00;
                    1: b = sirs_pkg::SYM_PLUS;
                    2: b = sirs_pkg::SYM_MINUS;
                    3: b = sirs_pkg::SYM_SPACE;
                    default: b = sirs_pkg::CTRL_LOW + 8'($urandom_range(4));
                endcase
                t[$urandom_range(n - 1)] = b;
            end
            2: begin
                i    = $urandom_range(1, n - 1);
                t[i] = t[$urandom_range(i - 1)];
            end
            default: ;
        endcase
        cnt = 5'(n);
        for (i = 0; i < 8; i++) begin
            lo[8*i +: 8] = t[i];
            hi[8*i +: 8] = t[i+8];
        end
    endtask

    function automatic logic [31:0] random_number();
        case ($urandom_range(3))
            0: return 32'($signed($urandom_range(80)) - 40);
            1: return 32'h8000_0000 + 32'($urandom_range(40));
            2: return 32'h7FFF_FFFF - 32'($urandom_range(40));
            default: return $urandom;
        endcase
    endfunction

    localparam logic [63:0] DIGITS_LO = 64'h3736353433323130;
    localparam logic [63:0] DIGITS_HI = 64'h4645444342413938;
    localparam logic [63:0] EDGE_LO   = 64'h2E2C2A211F0E0801;
    localparam logic [63:0] EDGE_HI   = 64'h3F7A615A7F80FEFF;

    initial begin
        logic [4:0]  cnt;
        logic [63:0] lo;
        logic [63:0] hi;
        int          phase;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_number     = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        hold_request  = 1'b0;
        idle_cycles   = 0;
        send_idle_pct = 30;
        recv_idle_pct = 60;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // decimal
        load_table(5'd10, DIGITS_LO, DIGITS_HI);
        send_number(0);
        send_number(1);
        send_number(-1);
        send_number(32'sh7FFF_FFFF);
        send_number(32'sh8000_0000);
        send_number(10);
        send_number(-999);
        settle();
        // hex
        load_table(5'd16, DIGITS_LO, DIGITS_HI);
        send_number(32'sh8000_0000);
        send_number(32'sh5A3C_96E1);
        send_number(15);
        settle();
        // binary, longest output
        load_table(5'd2, DIGITS_LO, DIGITS_HI);
        send_number(-1);
        send_number(32'sh8000_0000);
        settle();
        // symbols at the edges of the reserved ranges
        load_table(5'd16, EDGE_LO, EDGE_HI);
        send_number(123456789);
        settle();
        // bytes beyond the count are ignored
        load_table(5'd3, 64'h0000_0000_0033_2211, 64'h0D0D_2D2D_2B2B_0909);
        send_number(-7);
        settle();
        // rejected tables
        load_table(5'd0, DIGITS_LO, DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd1, DIGITS_LO, DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd17, DIGITS_LO, DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd31, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_number(5);
        settle();
        load_table(5'd10, 64'h3736353433003130, DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd10, {DIGITS_LO[63:8], sirs_pkg::SYM_PLUS}, DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd10, DIGITS_LO,
                   {DIGITS_HI[63:16], sirs_pkg::SYM_MINUS, DIGITS_HI[7:0]});
        send_number(5);
        settle();
        load_table(5'd4, {DIGITS_LO[63:32], sirs_pkg::SYM_SPACE, DIGITS_LO[23:0]},
                   DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd4, {DIGITS_LO[63:16], sirs_pkg::CTRL_LOW, DIGITS_LO[7:0]},
                   DIGITS_HI);
        send_number(5);
        settle();
        load_table(5'd16, DIGITS_LO, {sirs_pkg::CTRL_HIGH, DIGITS_HI[55:0]});
        send_number(5);
        settle();
        load_table(5'd16, DIGITS_LO, {8'h30, DIGITS_HI[55:0]});
        send_number(5);
        settle();

        // long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_table(5'd2, DIGITS_LO, DIGITS_HI);
        hold_request = 1'b1;
        repeat (8) send_number(32'h8000_0000 | $urandom);
        settle();

        for (phase = 0; phase < PHASES; phase++) begin
            if (phase < PHASES / 3) begin
                send_idle_pct = 30;
                recv_idle_pct = 60;
            end else if (phase < 2 * PHASES / 3) begin
                send_idle_pct = 60;
                recv_idle_pct = 30;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            random_table(cnt, lo, hi);
            load_table(cnt, lo, hi);
            repeat (PHASE_ITEMS) send_number(random_number());
            settle();
        end

        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/sirs_pkg.sv
design/sirs_front.sv
design/sirs_queue.sv
design/sirs_back.sv
design/signed_integer_to_radix_symbols.sv
dv/signed_integer_to_radix_symbols_tb.sv
